@@ hdl/ere_pkg.sv @@
// ----------------------------------------------------------------------------
// ere_pkg
// Shared types and constants of the edit record encoder: event kinds, error
// codes, unit encoding constants and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package ere_pkg;

  localparam int unsigned RemW      = 19;
  localparam int unsigned PendDepth = 5;
  localparam int unsigned PendCntW  = 3;

  localparam logic [15:0]     UnchUnitMax   = 16'h0fff;
  localparam logic [RemW-1:0] UnchLenMax    = RemW'(4096);
  localparam logic [15:0]     ShortUnitMax  = 16'h6fff;
  localparam logic [30:0]     ShortWidthMax = 31'd6;
  localparam logic [5:0]      FieldOneTrail = 6'd61;
  localparam logic [5:0]      FieldTwoTrail = 6'd62;
  localparam logic [15:0]     HeadBase      = 16'h7000;
  localparam logic [15:0]     TrailFlag     = 16'h8000;
  localparam logic [30:0]     TrailMax      = 31'h7fff;
  localparam logic [30:0]     SpanLimit     = 31'd262144;
  localparam logic [30:0]     CountMax      = 31'h7fffffff;

  typedef enum logic [1:0] {
    KindUnch = 2'd0,
    KindRepl = 2'd1,
    KindFin  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrNeg  = 2'd1,
    ErrOvf  = 2'd2,
    ErrSpan = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEval = 3'b010,
    StPush = 3'b100
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_push;
    logic push_final;
  } sts_t;

endpackage

@@ hdl/ere_ctrl.sv @@
// ----------------------------------------------------------------------------
// ere_ctrl
// Sequencer of the edit record encoder: takes a request, has the datapath
// evaluate it, then steps it through one push per cycle while the output is free.
// ----------------------------------------------------------------------------
module ere_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ere_pkg::sts_t sts_i,
  output ere_pkg::cmd_t cmd_o
);
  import ere_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.eval    = 1'b0;
    cmd_o.push    = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StEval;
        end
      end
      StEval: begin
        if (sts_i.out_free) begin
          cmd_o.eval = 1'b1;
          state_d    = sts_i.start_push ? StPush : StIdle;
        end
      end
      StPush: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          if (sts_i.push_final) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ere_datapath.sv @@
// ----------------------------------------------------------------------------
// ere_datapath
// Encoder state, event evaluation, pending unit list, span splitter and the
// output register.
// ----------------------------------------------------------------------------
module ere_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ere_pkg::cmd_t        cmd_i,
  output ere_pkg::sts_t        sts_o,
  input  logic [1:0]           kind_i,
  input  logic signed [31:0]   first_length_i,
  input  logic signed [31:0]   second_length_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 has_unit_o,
  output logic [15:0]          record_unit_o,
  output logic                 is_last_o,
  output logic signed [31:0]   total_delta_o,
  output logic [30:0]          change_count_o,
  output logic [1:0]           error_code_o
);
  import ere_pkg::*;

  typedef struct packed {
    logic [5:0]  field;
    logic [1:0]  n;
    logic [15:0] t0;
    logic [15:0] t1;
  } lf_t;

  function automatic lf_t len_field(input logic [30:0] v);
    lf_t r;
    r.field = v[5:0];
    r.n     = 2'd0;
    r.t0    = '0;
    r.t1    = '0;
    if (v < 31'(FieldOneTrail)) begin
      r.field = v[5:0];
    end else if (v <= TrailMax) begin
      r.field = FieldOneTrail;
      r.n     = 2'd1;
      r.t0    = TrailFlag | {1'b0, v[14:0]};
    end else begin
      r.field = FieldTwoTrail + {5'd0, v[30]};
      r.n     = 2'd2;
      r.t0    = TrailFlag | {1'b0, v[29:15]};
      r.t1    = TrailFlag | {1'b0, v[14:0]};
    end
    return r;
  endfunction

  logic [1:0]         kind_q, kind_d;
  logic signed [31:0] first_q, first_d, second_q, second_d;
  logic signed [32:0] diff_q, diff_d;

  logic [15:0]        held_unit_q, held_unit_d;
  logic               held_valid_q, held_valid_d;
  logic signed [31:0] delta_q, delta_d;
  logic [30:0]        count_q, count_d;
  err_e               err_q, err_d;

  logic                span_q, span_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [15:0]         pend_q [PendDepth];
  logic [15:0]         pend_d [PendDepth];
  logic [PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  logic               out_valid_q, out_valid_d;
  logic               has_q, has_d;
  logic [15:0]        unit_q, unit_d;
  logic               last_q, last_d;
  logic signed [31:0] odelta_q, odelta_d;
  logic [30:0]        ocount_q, ocount_d;
  logic [1:0]         oerr_q, oerr_d;

  logic [15:0]         last_unit;
  logic [11:0]         room;
  logic                below;
  logic [RemW-1:0]     len19;
  logic                fits;
  logic [RemW-1:0]     rem_start;
  logic                too_long;
  logic                short_same;
  logic                short_merge;
  logic [30:0]         count_inc;
  logic signed [33:0]  nd;
  logic                ovf;
  lf_t                 fo, fn;
  logic [15:0]         seq [PendDepth];
  logic [PendCntW-1:0] seq_cnt;
  logic                span_big;
  logic [15:0]         push_unit;
  logic                out_free;
  logic                start_push;
  logic                push_final;

  assign out_free  = !out_valid_q || out_ready_i;
  assign span_big  = rem_q >= UnchLenMax;
  assign push_unit = span_q ? (span_big ? UnchUnitMax : {4'h0, rem_q[11:0] - 12'd1})
                            : pend_q[0];

  assign push_final = span_q ? (rem_q <= UnchLenMax) : (pend_cnt_q == PendCntW'(1));
  assign sts_o      = '{out_free: out_free, start_push: start_push, push_final: push_final};

  always_comb begin
    last_unit   = held_valid_q ? held_unit_q : 16'hffff;
    below       = last_unit < UnchUnitMax;
    room        = UnchUnitMax[11:0] - last_unit[11:0];
    len19       = first_q[RemW-1:0];
    too_long    = first_q[30:0] > SpanLimit;
    fits        = below && ({7'd0, room} >= len19);
    rem_start   = below ? (len19 - {7'd0, room}) : len19;
    short_same  = (first_q == second_q) && !first_q[31] && (first_q != 32'sd0)
                  && (first_q[30:0] <= ShortWidthMax);
    short_merge = (last_unit > UnchUnitMax) && (last_unit < ShortUnitMax)
                  && (last_unit[15:12] == {1'b0, first_q[2:0]})
                  && (last_unit[11:0] < UnchUnitMax[11:0]);
    count_inc   = (count_q == CountMax) ? count_q : count_q + 31'd1;
    nd          = {{2{delta_q[31]}}, delta_q} + {diff_q[32], diff_q};
    ovf         = (nd[33:31] != 3'b000) && (nd[33:31] != 3'b111);
    fo          = len_field(first_q[30:0]);
    fn          = len_field(second_q[30:0]);
    for (int i = 0; i < PendDepth; i++) begin
      seq[i] = '0;
    end
    seq[0] = HeadBase | {4'h0, fo.field, fn.field};
    case (fo.n)
      2'd0: begin
        seq[1] = fn.t0;
        seq[2] = fn.t1;
      end
      2'd1: begin
        seq[1] = fo.t0;
        seq[2] = fn.t0;
        seq[3] = fn.t1;
      end
      default: begin
        seq[1] = fo.t0;
        seq[2] = fo.t1;
        seq[3] = fn.t0;
        seq[4] = fn.t1;
      end
    endcase
    seq_cnt = PendCntW'(1) + PendCntW'(fo.n) + PendCntW'(fn.n);
  end

  always_comb begin
    kind_d       = kind_q;
    first_d      = first_q;
    second_d     = second_q;
    diff_d       = diff_q;
    held_unit_d  = held_unit_q;
    held_valid_d = held_valid_q;
    delta_d      = delta_q;
    count_d      = count_q;
    err_d        = err_q;
    span_d       = span_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    pend_cnt_d   = pend_cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    has_d        = has_q;
    unit_d       = unit_q;
    last_d       = last_q;
    odelta_d     = odelta_q;
    ocount_d     = ocount_q;
    oerr_d       = oerr_q;
    start_push   = 1'b0;

    if (cmd_i.capture) begin
      kind_d   = kind_i;
      first_d  = first_length_i;
      second_d = second_length_i;
      diff_d   = {second_length_i[31], second_length_i} - {first_length_i[31], first_length_i};
    end

    if (cmd_i.eval) begin
      case (kind_q)
        KindUnch: begin
          if (err_q == ErrNone && first_q != 32'sd0) begin
            if (first_q[31]) begin
              err_d = ErrNeg;
            end else if (too_long) begin
              err_d = ErrSpan;
            end else if (fits) begin
              held_unit_d = {4'h0, last_unit[11:0] + len19[11:0]};
            end else begin
              if (below) begin
                held_unit_d = UnchUnitMax;
              end
              span_d     = 1'b1;
              rem_d      = rem_start;
              start_push = 1'b1;
            end
          end
        end
        KindRepl: begin
          if (err_q == ErrNone) begin
            if (short_same) begin
              count_d = count_inc;
              if (short_merge) begin
                held_unit_d = held_unit_q + 16'd1;
              end else begin
                span_d     = 1'b0;
                pend_d[0]  = {1'b0, first_q[2:0], 12'h000};
                pend_cnt_d = PendCntW'(1);
                start_push = 1'b1;
              end
            end else if (first_q[31] || second_q[31]) begin
              err_d = ErrNeg;
            end else if (first_q != 32'sd0 || second_q != 32'sd0) begin
              count_d = count_inc;
              if (ovf) begin
                err_d = ErrOvf;
              end else begin
                delta_d    = nd[31:0];
                span_d     = 1'b0;
                pend_d     = seq;
                pend_cnt_d = seq_cnt;
                start_push = 1'b1;
              end
            end
          end
        end
        KindFin: begin
          out_valid_d  = 1'b1;
          has_d        = held_valid_q;
          unit_d       = held_valid_q ? held_unit_q : 16'h0000;
          last_d       = 1'b1;
          odelta_d     = delta_q;
          ocount_d     = count_q;
          oerr_d       = err_q;
          held_unit_d  = '0;
          held_valid_d = 1'b0;
          delta_d      = '0;
          count_d      = '0;
          err_d        = ErrNone;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.push) begin
      if (held_valid_q) begin
        out_valid_d = 1'b1;
        has_d       = 1'b1;
        unit_d      = held_unit_q;
        last_d      = push_final;
        odelta_d    = '0;
        ocount_d    = '0;
        oerr_d      = err_q;
      end
      held_unit_d  = push_unit;
      held_valid_d = 1'b1;
      if (span_q) begin
        rem_d = span_big ? rem_q - UnchLenMax : '0;
      end else begin
        for (int i = 0; i < PendDepth - 1; i++) begin
          pend_d[i] = pend_q[i+1];
        end
        pend_cnt_d = pend_cnt_q - PendCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_unit_q  <= '0;
      held_valid_q <= 1'b0;
      delta_q      <= '0;
      count_q      <= '0;
      err_q        <= ErrNone;
      span_q       <= 1'b0;
      rem_q        <= '0;
      pend_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      held_unit_q  <= held_unit_d;
      held_valid_q <= held_valid_d;
      delta_q      <= delta_d;
      count_q      <= count_d;
      err_q        <= err_d;
      span_q       <= span_d;
      rem_q        <= rem_d;
      pend_cnt_q   <= pend_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    first_q  <= first_d;
    second_q <= second_d;
    diff_q   <= diff_d;
    pend_q   <= pend_d;
    has_q    <= has_d;
    unit_q   <= unit_d;
    last_q   <= last_d;
    odelta_q <= odelta_d;
    ocount_q <= ocount_d;
    oerr_q   <= oerr_d;
  end

  assign out_valid_o    = out_valid_q;
  assign has_unit_o     = has_q;
  assign record_unit_o  = unit_q;
  assign is_last_o      = last_q;
  assign total_delta_o  = odelta_q;
  assign change_count_o = ocount_q;
  assign error_code_o   = oerr_q;

  a_push_holds_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> held_valid_q)
    else $error("held unit not valid after a push");

  a_span_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && span_q) |-> (rem_q != '0))
    else $error("span push with nothing remaining");

  a_empty_result_is_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_q) |-> last_q)
    else $error("result without unit that is not a finish result");

  a_sticky_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |=> (err_q == $past(err_q) || err_q == ErrNone))
    else $error("sticky error changed without a clear");

endmodule

@@ hdl/edit_record_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// edit_record_encoder_unit
// Turns edit events into a stream of 16-bit edit record units with running
// totals, error tracking and a finish report.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request is accepted, then evaluated,
// then the held-unit push sequencer pushes each of its units into the held
// slot, one push per cycle while the output is not stalled. An event that
// only merges or only flags an error pushes no unit, a short replacement
// pushes one, a long-form replacement up to five, and an unchanged span
// about one per 4096 of its length. Each pushed unit releases the previously
// held unit as a result; finish releases the held unit together with the
// totals.
module edit_record_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic signed [31:0]  first_length_i,
  input  logic signed [31:0]  second_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                has_unit_o,
  output logic [15:0]         record_unit_o,
  output logic                is_last_o,
  output logic signed [31:0]  total_delta_o,
  output logic [30:0]         change_count_o,
  output logic [1:0]          error_code_o
);
  import ere_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ere_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ere_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .first_length_i  (first_length_i),
    .second_length_i (second_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .has_unit_o      (has_unit_o),
    .record_unit_o   (record_unit_o),
    .is_last_o       (is_last_o),
    .total_delta_o   (total_delta_o),
    .change_count_o  (change_count_o),
    .error_code_o    (error_code_o)
  );

endmodule

@@ sim/edit_record_encoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_record_encoder_unit_tb
// Self-checking bench for the edit record encoder. Edit events go in over a
// valid/ready channel with random gaps. A cycle-accurate-free predictor tracks
// the held unit, running delta, change count and sticky error and queues the
// expected record results. Each result leaving the block is checked field by
// field against the oldest expectation, under random output back-pressure.
// ----------------------------------------------------------------------------
module edit_record_encoder_unit_tb;
  import ere_pkg::*;

  localparam logic [1:0] KindUnknown = 2'd3;
  localparam int         CycleLimit  = 600000;
  localparam int         DrainCycles = 100;
  localparam int         PrintLimit  = 40;

  typedef struct {
    logic               has_unit;
    logic [15:0]        record_unit;
    logic               is_last;
    logic signed [31:0] total_delta;
    logic [30:0]        change_count;
    err_e               error_code;
  } edit_record_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i          = 2'd0;
  logic signed [31:0] first_length_i  = 32'sd0;
  logic signed [31:0] second_length_i = 32'sd0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic               has_unit_o;
  logic [15:0]        record_unit_o;
  logic               is_last_o;
  logic signed [31:0] total_delta_o;
  logic [30:0]        change_count_o;
  logic [1:0]         error_code_o;

  edit_record_t expected_records[$];
  logic [15:0]  trail_units[$];

  logic [15:0]  slot_unit    = 16'h0;
  logic         slot_full    = 1'b0;
  int           delta_acc    = 0;
  logic [30:0]  change_tally = 31'd0;
  err_e         fault_code   = ErrNone;
  int           records_made = 0;

  int fail_count  = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit idle_en     = 1'b1;

  edit_record_encoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .first_length_i  (first_length_i),
    .second_length_i (second_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .has_unit_o      (has_unit_o),
    .record_unit_o   (record_unit_o),
    .is_last_o       (is_last_o),
    .total_delta_o   (total_delta_o),
    .change_count_o  (change_count_o),
    .error_code_o    (error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("edit_record_encoder_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void release_record(logic has, logic [15:0] unit,
                                         logic signed [31:0] delta, logic [30:0] cnt);
    edit_record_t r;
    r.has_unit     = has;
    r.record_unit  = unit;
    r.is_last      = 1'b0;
    r.total_delta  = delta;
    r.change_count = cnt;
    r.error_code   = fault_code;
    expected_records.push_back(r);
    records_made++;
  endfunction

  function automatic void load_slot(logic [15:0] unit);
    if (slot_full) release_record(1'b1, slot_unit, 32'sd0, 31'd0);
    slot_unit = unit;
    slot_full = 1'b1;
  endfunction

  function automatic int slot_view();
    return slot_full ? int'(slot_unit) : 32'hffff;
  endfunction

  function automatic void tally_change();
    if (change_tally < CountMax) change_tally++;
  endfunction

  function automatic void encode_span(longint len);
    int     last;
    longint room;
    if (fault_code != ErrNone || len == 0) return;
    if (len < 0) begin
      fault_code = ErrNeg;
      return;
    end
    if (len > longint'(SpanLimit)) begin
      fault_code = ErrSpan;
      return;
    end
    last = slot_view();
    if (last < int'(UnchUnitMax)) begin
      room = int'(UnchUnitMax) - last;
      if (room >= len) begin
        slot_unit = 16'(last + len);
        return;
      end
      slot_unit = UnchUnitMax;
      len -= room;
    end
    while (len >= longint'(UnchLenMax)) begin
      load_slot(UnchUnitMax);
      len -= longint'(UnchLenMax);
    end
    if (len > 0) load_slot(16'(len - 1));
  endfunction

  function automatic logic [5:0] length_field(longint len);
    logic [31:0] v;
    v = len[31:0];
    if (len < longint'(FieldOneTrail)) return v[5:0];
    if (len <= longint'(TrailMax)) begin
      trail_units.push_back(TrailFlag | v[15:0]);
      return FieldOneTrail;
    end
    trail_units.push_back(TrailFlag | {1'b0, v[29:15]});
    trail_units.push_back(TrailFlag | {1'b0, v[14:0]});
    return FieldTwoTrail + 6'(v[30]);
  endfunction

  function automatic void encode_replace(longint old_len, longint new_len);
    int          last;
    longint      next_delta;
    logic [5:0]  old_field;
    logic [5:0]  new_field;
    if (fault_code != ErrNone) return;
    if (old_len == new_len && old_len > 0 && old_len <= longint'(ShortWidthMax)) begin
      last = slot_view();
      tally_change();
      if (last > int'(UnchUnitMax) && last < int'(ShortUnitMax) && (last >> 12) == old_len
          && (last & 32'shfff) < int'(UnchUnitMax))
        slot_unit = 16'(last + 1);
      else
        load_slot(16'(old_len << 12));
      return;
    end
    if (old_len < 0 || new_len < 0) begin
      fault_code = ErrNeg;
      return;
    end
    if (old_len == 0 && new_len == 0) return;
    tally_change();
    next_delta = longint'(delta_acc) + (new_len - old_len);
    if (next_delta != longint'(int'(next_delta))) begin
      fault_code = ErrOvf;
      return;
    end
    delta_acc = int'(next_delta);
    trail_units.delete();
    old_field = length_field(old_len);
    new_field = length_field(new_len);
    load_slot(HeadBase | {4'b0, old_field, new_field});
    foreach (trail_units[i]) load_slot(trail_units[i]);
  endfunction

  function automatic void encode_event(logic [1:0] kind, longint first_len,
                                       longint second_len);
    records_made = 0;
    case (kind)
      KindUnch: encode_span(first_len);
      KindRepl: encode_replace(first_len, second_len);
      KindFin: begin
        release_record(slot_full, slot_full ? slot_unit : 16'h0, delta_acc, change_tally);
        slot_unit    = 16'h0;
        slot_full    = 1'b0;
        delta_acc    = 0;
        change_tally = 31'd0;
        fault_code   = ErrNone;
      end
      default: ;
    endcase
    if (records_made != 0) expected_records[expected_records.size() - 1].is_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, longint got, longint want);
    fail_count++;
    if (fail_count <= PrintLimit)
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    edit_record_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_records.size() == 0) begin
        report_mismatch("unexpected record_unit", record_unit_o, 0);
      end else begin
        want = expected_records.pop_front();
        if (has_unit_o !== want.has_unit)
          report_mismatch("has_unit", has_unit_o, want.has_unit);
        if (record_unit_o !== want.record_unit)
          report_mismatch("record_unit", record_unit_o, want.record_unit);
        if (is_last_o !== want.is_last)
          report_mismatch("is_last", is_last_o, want.is_last);
        if (total_delta_o !== want.total_delta)
          report_mismatch("total_delta", total_delta_o, want.total_delta);
        if (change_count_o !== want.change_count)
          report_mismatch("change_count", change_count_o, want.change_count);
        if (error_code_o !== want.error_code)
          report_mismatch("error_code", error_code_o, want.error_code);
      end
    end
  end

  // hold off on request, else stall in random bursts while idle_en is set
  initial begin : receiver
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_event(logic [1:0] kind, logic signed [31:0] first_len,
                            logic signed [31:0] second_len);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    first_length_i  <= first_len;
    second_length_i <= second_len;
    do @(posedge clk_i); while (!in_ready_o);
    encode_event(kind, first_len, second_len);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_records.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_span();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return $urandom_range(1, 200);
    if (sel < 15) return $urandom_range(200, 5000);
    if (sel < 17) return $urandom_range(4096, 20000);
    if (sel < 18) return 0;
    if (sel < 19) return $urandom_range(20000, 262144);
    if ($urandom_range(0, 1) == 0) return {1'b1, 31'($urandom)};
    return $urandom_range(262145, 32'h7fffffff);
  endfunction

  function automatic logic signed [31:0] rand_repl_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 4) return $urandom_range(1, 6);
    if (sel < 8) return $urandom_range(0, 60);
    if (sel < 12) return $urandom_range(61, 32'h7fff);
    if (sel < 15) return $urandom_range(32'h8000, 32'h3fffffff);
    if (sel < 16) return $urandom_range(32'h40000000, 32'h7fffffff);
    if (sel < 17) return 0;
    return $urandom_range(1, 60);
  endfunction

  task automatic send_random_event();
    int sel;
    int width;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      send_event(KindUnch, rand_span(), $urandom);
    end else if (sel < 65) begin
      width = $urandom_range(1, 6);
      send_event(KindRepl, width, width);
    end else if (sel < 88) begin
      send_event(KindRepl, rand_repl_len(), rand_repl_len());
    end else if (sel < 94) begin
      send_event(KindFin, $urandom, $urandom);
    end else if (sel < 97) begin
      if ($urandom_range(0, 1) == 0)
        send_event(KindRepl, {1'b1, 31'($urandom)}, rand_repl_len());
      else
        send_event(KindRepl, rand_repl_len(), {1'b1, 31'($urandom)});
    end else begin
      send_event(KindUnknown, $urandom, $urandom);
    end
  endtask

  task automatic test_directed_cases();
    send_event(KindUnch, 1, 0);
    send_event(KindUnch, 4094, 0);
    send_event(KindUnch, 2, 0);
    send_event(KindUnch, 262144, 0);
    send_event(KindUnch, 262145, 0);
    send_event(KindUnch, 5, 0);
    send_event(KindFin, 0, 0);
    send_event(KindRepl, 3, 3);
    send_event(KindRepl, 3, 3);
    send_event(KindRepl, 1, 1);
    send_event(KindRepl, 6, 6);
    send_event(KindRepl, 0, 0);
    send_event(KindUnch, 0, 0);
    send_event(KindRepl, 0, 60);
    send_event(KindRepl, 61, 32'h7fff);
    send_event(KindRepl, 32'h8000, 32'h3fffffff);
    send_event(KindRepl, 32'h7fffffff, 32'h40000000);
    send_event(KindRepl, 0, 32'h7fffffff);
    send_event(KindRepl, 0, 7);
    send_event(KindFin, 0, 0);
    send_event(KindUnch, 32'h80000000, 32'h80000000);
    send_event(KindFin, 0, 0);
    send_event(KindRepl, 4, -1);
    send_event(KindUnknown, $urandom, $urandom);
    send_event(KindFin, 0, 0);
  endtask

  task automatic test_random_events();
    repeat (70) send_random_event();
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 300;
    repeat (15) begin
      if ($urandom_range(0, 2) == 0)
        send_event(KindRepl, $urandom_range(32'h8000, 32'h7fffffff), $urandom_range(61, 5000));
      else
        send_event(KindUnch, $urandom_range(8192, 16384), 0);
    end
    wait_drained();
    send_event(KindFin, 0, 0);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (20) send_random_event();
    send_event(KindFin, 0, 0);
  endtask

  initial begin : main_sequence
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_events();
    test_output_backpressure();
    test_no_idle();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_records.size() != 0)
      report_mismatch("results left over", expected_records.size(), 0);
    if (fail_count == 0)
      $display("edit_record_encoder_unit_tb: PASS");
    else
      $display("edit_record_encoder_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ere_pkg.sv
hdl/ere_ctrl.sv
hdl/ere_datapath.sv
hdl/edit_record_encoder_unit.sv
sim/edit_record_encoder_unit_tb.sv
